// ===== rtl/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// maf_pkg
// Shared sizes and state codes for the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int SAMPLE_W   = 24;
   localparam int TOP_W      = 16;
   localparam int CSR_W      = 8;
   localparam int POS_W      = $clog2(MAX_WINDOW);
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W      = SAMPLE_W + POS_W;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [POS_W-1:0]    pos_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FILL   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_DIVIDE = 4'b1000
   } state_type;

endpackage

// ===== rtl/maf_req_if.sv =====
// ----------------------------------------------------------------------------
// maf_req_if
// Sample channel into the filter: valid/ready handshake with one sample.
// ----------------------------------------------------------------------------
interface maf_req_if;
   import maf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);

endinterface

// ===== rtl/maf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// maf_rsp_if
// Result channel out of the filter: valid/ready handshake with the average.
// ----------------------------------------------------------------------------
interface maf_rsp_if;
   import maf_pkg::*;

   logic                 valid;
   logic                 ready;
   sample_type           average;
   logic [TOP_W-1:0]     average_top16;

   modport source (output valid, output average, output average_top16, input ready);
   modport sink   (input valid, input average, input average_top16, output ready);

endinterface

// ===== rtl/moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over 24-bit samples with a programmable window.
// ----------------------------------------------------------------------------
// One item at a time: after a sample is accepted, an ordinary item passes
// through a read-modify-write step on the sample ring, then the bit-serial
// divider, then the output load, which waits until the output register is
// free. The first item after reset or after a change of the effective
// window length L first fills ring entries 0 to L-1, one per cycle, and
// then goes straight to the divider. A new sample is taken as soon as the
// previous one has reached the output register, even while that result
// still waits to be taken. A window length of 0 acts as 1 and values above
// 16 act as 16; a new length takes effect at the next sample.
module moving_average_filter (
   input  logic                         clock,
   input  logic                         reset,
   maf_req_if.sink                      req_chan,
   maf_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [maf_pkg::CSR_W-1:0]    csr_wr_data
);
   import maf_pkg::*;

   sample_type ring [MAX_WINDOW];
   sample_type ring_rd_ff;
   logic       ring_we;
   pos_type    ring_waddr;

   state_type  state_ff, state_in;
   logic [CSR_W-1:0] wlen_ff, wlen_in;
   logic       primed_ff, primed_in;
   len_type    len_use_ff, len_use_in;
   pos_type    pos_ff, pos_in;
   sum_type    sum_ff, sum_in;
   sample_type sample_ff, sample_in;
   len_type    fill_ff, fill_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type avg_ff, avg_in;

   len_type    eff_len;
   sum_type    prime_sum;
   logic       req_take;
   logic       div_start;
   sum_type    div_dividend;
   logic       div_busy;
   sample_type div_quotient;
   logic       out_free;

   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if ({{(32-CSR_W){1'b0}}, wlen_ff} > MAX_WINDOW) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = LEN_W'(wlen_ff);
      end
   end

   assign prime_sum = SUM_W'({{(SUM_W-SAMPLE_W){1'b0}}, sample_ff}
                             * {{(SUM_W-LEN_W){1'b0}}, len_use_ff});
   assign req_take  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      wlen_in      = csr_wr_en ? csr_wr_data : wlen_ff;
      primed_in    = primed_ff;
      len_use_in   = len_use_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      avg_in       = avg_ff;
      ring_we      = 1'b0;
      ring_waddr   = pos_ff;
      div_start    = 1'b0;
      div_dividend = sum_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_chan.sample;
               if (!primed_ff || eff_len != len_use_ff) begin
                  len_use_in = eff_len;
                  primed_in  = 1'b1;
                  fill_in    = '0;
                  state_in   = ST_FILL;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_FILL: begin
            ring_we    = 1'b1;
            ring_waddr = fill_ff[POS_W-1:0];
            fill_in    = fill_ff + 1'b1;
            if (fill_ff == len_use_ff - 1'b1) begin
               // Entry 0 is then replaced by the same sample, so the sum stays
               // at sample times length and the oldest entry is entry 1.
               sum_in       = prime_sum;
               pos_in       = (len_use_ff == LEN_W'(1)) ? '0 : POS_W'(1);
               div_start    = 1'b1;
               div_dividend = prime_sum;
               state_in     = ST_DIVIDE;
            end
         end
         ST_UPDATE: begin
            // ring_rd_ff holds the oldest entry, read while the item was taken.
            sum_in       = sum_ff + {{(SUM_W-SAMPLE_W){1'b0}}, sample_ff}
                                  - {{(SUM_W-SAMPLE_W){1'b0}}, ring_rd_ff};
            ring_we      = 1'b1;
            ring_waddr   = pos_ff;
            if ({1'b0, pos_ff} + LEN_W'(1) >= len_use_ff) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
            div_start    = 1'b1;
            div_dividend = sum_in;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy && out_free) begin
               avg_in       = div_quotient;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[ring_waddr] <= sample_ff;
      end
      ring_rd_ff <= ring[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= CSR_W'(16);
         primed_ff    <= 1'b0;
         len_use_ff   <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         primed_ff    <= primed_in;
         len_use_ff   <= len_use_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      fill_ff   <= fill_in;
      avg_ff    <= avg_in;
   end

   maf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (len_use_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.average       = avg_ff;
   assign rsp_chan.average_top16 = avg_ff[SAMPLE_W-1:SAMPLE_W-TOP_W];

endmodule

// ===== rtl/maf_divider.sv =====
// ----------------------------------------------------------------------------
// maf_divider
// Restoring divider, one quotient bit per cycle, running sum by window length.
// ----------------------------------------------------------------------------
module maf_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  maf_pkg::sum_type dividend,
   input  maf_pkg::len_type divisor,
   output logic             busy,
   output maf_pkg::sample_type quotient
);
   import maf_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   sum_type               quo_ff, quo_in;
   logic [LEN_W:0]        rem_ff, rem_in;
   len_type               divisor_ff, divisor_in;

   logic [LEN_W:0]        rem_shift;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff[LEN_W-1:0], quo_ff[SUM_W-1]};
      fits      = (rem_shift >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(SUM_W);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         rem_in   = fits ? (rem_shift - {1'b0, divisor_ff}) : rem_shift;
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff   <= count_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   // The sum never exceeds length times the largest sample, so the quotient fits.
   assign quotient = quo_ff[SAMPLE_W-1:0];

endmodule

// ===== verif/tb_moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_filter
// Drives samples through the boxcar filter under a range of window lengths,
// with random idle and stall bursts on both channels. A scoreboard keeps its
// own ring and running sum, predicts each average and compares every item
// that comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_moving_average_filter;
   import maf_pkg::*;

   typedef struct packed {
      sample_type       average;
      logic [TOP_W-1:0] top16;
   } avg_result_type;

   class avg_scoreboard;
      bit [CSR_W-1:0] window_reg = 8'd16;
      sample_type     ring [MAX_WINDOW];
      bit [31:0]      run_sum;
      int unsigned    ring_pos;
      int unsigned    len_used;
      bit             primed;
      avg_result_type pending_q [$];
      int unsigned    errors;
      int unsigned    reported;

      function int unsigned eff_len();
         int unsigned len;
         len = window_reg;
         if (len == 0) len = 1;
         if (len > MAX_WINDOW) len = MAX_WINDOW;
         return len;
      endfunction

      // Called for every accepted sample; queues the average it must produce.
      function void note_sample(sample_type s);
         int unsigned len;
         int unsigned i;
         avg_result_type want;
         len = eff_len();
         if (!primed || len != len_used) begin
            for (i = 0; i < len; i++) ring[i] = s;
            run_sum  = s * len;
            ring_pos = 0;
            len_used = len;
            primed   = 1'b1;
         end
         run_sum = run_sum + s - ring[ring_pos];
         ring[ring_pos] = s;
         ring_pos = (ring_pos + 1 >= len) ? 0 : ring_pos + 1;
         want.average = sample_type'(run_sum / len);
         want.top16   = want.average[SAMPLE_W-1 -: TOP_W];
         pending_q.push_back(want);
      endfunction

      function void flag();
         errors++;
         reported++;
      endfunction

      function void check_average(sample_type avg, logic [TOP_W-1:0] top);
         avg_result_type want;
         if (pending_q.size() == 0) begin
            flag();
            if (reported <= 200)
               $display("%0t: unexpected result, average %h top16 %h", $time, avg, top);
         end else begin
            want = pending_q.pop_front();
            if (avg !== want.average) begin
               flag();
               if (reported <= 200)
                  $display("%0t: average mismatch, expected %h actual %h",
                           $time, want.average, avg);
            end
            if (top !== want.top16) begin
               flag();
               if (reported <= 200)
                  $display("%0t: average_top16 mismatch, expected %h actual %h",
                           $time, want.top16, top);
            end
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   maf_req_if req_bus ();
   maf_rsp_if rsp_bus ();

   moving_average_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   avg_scoreboard sb = new;
   bit            no_idle = 1'b0;
   int unsigned   sent = 0;
   int unsigned   stall_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: check every accepted item and stall ready in short bursts.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_average(rsp_bus.average, rsp_bus.average_top16);
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 4) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_sample(input sample_type s);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_sample(s);
      sent++;
   endtask

   // Lowers valid in the step of the last acceptance, then lets all results out.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_window(input logic [CSR_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.window_reg = v;
      @(posedge clock);
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         2: return sample_type'($urandom_range(24'hFFFF00, 24'hFFFFFF));
         3: return sample_type'($urandom_range(0, 255));
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] random_window();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(17, 255));
         3: return 8'd16;
         4: return 8'd1;
         default: return 8'($urandom_range(2, 15));
      endcase
   endfunction

   initial begin
      sample_type opening [8];
      int unsigned n;
      int unsigned i;
      opening = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                  24'hAAAAAA, 24'h555555, 24'h000001, 24'h800000};

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Default length straight out of reset; the first item primes the ring.
      foreach (opening[k]) send_sample(opening[k]);
      drain();

      // A length of zero acts as one.
      write_window(8'd0);
      send_sample(24'hFFFFFF);
      send_sample(24'h000000);
      send_sample(24'h123456);
      drain();

      // Oversized length saturates and re-primes from a length of one.
      write_window(8'd255);
      send_sample(24'hFFFFFF);
      send_sample(24'h000000);
      drain();

      // Another oversized value maps to the same length, so no re-prime.
      write_window(8'd17);
      send_sample(24'hFFFFFF);
      send_sample(24'h00FF00);
      send_sample(24'hFFFFFF);
      drain();

      // Two writes before any item: only the last one counts.
      write_window(8'd5);
      write_window(8'd2);
      send_sample(24'h7FFFFF);
      send_sample(24'hFFFFFF);
      send_sample(24'h000003);
      drain();

      write_window(8'd16);
      send_sample(24'hFFFFFE);
      send_sample(24'h000001);
      drain();

      while (sent < 1800) begin
         if (sent >= 1500) no_idle = 1'b1;
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 3) == 0) write_window(random_window());
            write_window(random_window());
         end
         n = $urandom_range(10, 80);
         for (i = 0; i < n; i++) send_sample(random_sample());
         drain();
      end

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
